// ===== design/lcks_pkg.sv =====
// Shared types and constants for the LFSR CDF key sampler.
package lcks_pkg;

    // Field widths of the input and result words.
    localparam int KEY_W    = 20;
    localparam int SAMPLE_W = 32;
    localparam int WEIGHT_W = 32;
    localparam int KC_W     = 21;
    localparam int CFG_W    = 32;

    // Command codes carried in the cmd field.
    localparam logic [0:0] CMD_LOAD = 1'b0;
    localparam logic [0:0] CMD_DRAW = 1'b1;

    // Configuration register indexes.
    localparam logic [0:0] CFG_KEY_COUNT = 1'b0;
    localparam logic [0:0] CFG_LFSR_SEED = 1'b1;

    // Register reset values and generator taps.
    localparam logic [KC_W-1:0]     KEY_COUNT_RESET = 21'd1048576;
    localparam logic [SAMPLE_W-1:0] SEED_RESET      = 32'd1;
    localparam logic [SAMPLE_W-1:0] LFSR_TAPS       = 32'h8020_0003;

    // One input word.
    typedef struct packed {
        logic [0:0]          cmd;
        logic [KEY_W-1:0]    load_index;
        logic [WEIGHT_W-1:0] weight;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [SAMPLE_W-1:0] sample;
    } out_word_t;

    // Source of the emitted key.
    typedef enum logic [1:0] {
        KEY_LAST,
        KEY_LO,
        KEY_HI,
        KEY_MID
    } key_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_write;
        logic     draw_start;
        logic     search_issue;
        logic     init_bounds;
        logic     set_lo;
        logic     set_hi;
        logic     emit;
        key_sel_t key_sel;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gt_a;
        logic gt_b;
        logic n_is_one;
        logic mid_is_lo;
    } status_t;

endpackage

// ===== design/lfsr_cdf_key_sampler.sv =====
// Top level of the LFSR CDF key sampler: controller and datapath.
//
// A load word updates the running sum and stores it as the cumulative total
// of its key, and the block stays ready. A draw word steps the 32-bit
// generator and reads the last two cumulative totals; the next cycle either
// rejects the sample (no result), emits the last key, or starts a binary
// search. Each search step is a registered two-port table read of the
// midpoint and the entry below it followed by a compare, and the block
// accepts no new word until the draw has finished. The table is not cleared
// after reset: every key up to key_count - 1 must be loaded before drawing.
// The result appears with done high for exactly one cycle and cannot be held
// off; a new word may be accepted in that cycle.
module lfsr_cdf_key_sampler
    import lcks_pkg::*;
#(
    parameter int MAX_KEYS = 1048576
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_word_t         item,
    output logic             done,
    output out_word_t        result,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    ctrl_t   ctrl;
    status_t status;

    // Sequencer.
    lcks_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item_cmd (item.cmd),
        .status   (status),
        .ctrl     (ctrl),
        .busy     (busy),
        .done     (done)
    );

    // Storage and arithmetic.
    lcks_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .status    (status),
        .result    (result)
    );

endmodule

// ===== design/lcks_datapath.sv =====
// Datapath of the key sampler: table memory, running sum, generator and search bounds.
module lcks_datapath
    import lcks_pkg::*;
#(
    parameter int MAX_KEYS = 1048576
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  in_word_t         item,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  ctrl_t            ctrl,
    output status_t          status,
    output out_word_t        result
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    logic [KC_W-1:0]     key_count_reg;
    logic [SAMPLE_W-1:0] lfsr_reg;
    logic [SAMPLE_W-1:0] lfsr_next;
    logic [WEIGHT_W-1:0] running_sum_reg;
    logic [WEIGHT_W-1:0] running_sum_next;

    logic [WEIGHT_W-1:0] table_mem [MAX_KEYS];
    logic [WEIGHT_W-1:0] rd_a_reg;
    logic [WEIGHT_W-1:0] rd_b_reg;
    logic [AW-1:0]       addr_a;
    logic [AW-1:0]       addr_b;
    logic [AW-1:0]       wr_addr;
    logic                wr_en;

    logic [AW-1:0] lo_reg;
    logic [AW-1:0] lo_next;
    logic [AW-1:0] hi_reg;
    logic [AW-1:0] hi_next;
    logic [AW-1:0] mid_reg;
    logic          mid_is_lo_reg;
    logic [AW:0]   mid_sum;
    logic [AW-1:0] mid_comb;
    logic [AW-1:0] mid_comb_m1;

    logic [AW-1:0] last_idx;
    logic [AW-1:0] penult_idx;
    logic          n_is_one;

    logic [AW-1:0]       key_pick;
    logic [KEY_W-1:0]    key_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    // Last valid table index: zero counts as one key, large counts saturate.
    always_comb
    begin
        if (key_count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(key_count_reg) > 32'(MAX_KEYS))
        begin
            last_idx = AW'(MAX_KEYS - 1);
        end
        else
        begin
            last_idx = AW'(key_count_reg - KC_W'(1));
        end
    end

    assign n_is_one   = (last_idx == '0);
    assign penult_idx = n_is_one ? '0 : last_idx - AW'(1);

    // Midpoint of the current search interval and the entry just below it.
    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_comb    = mid_sum[AW:1];
    assign mid_comb_m1 = (mid_comb == '0) ? '0 : mid_comb - AW'(1);

    // Generator step and running sum update.
    assign lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
    assign running_sum_next = (item.load_index == '0) ?
                              item.weight : running_sum_reg + item.weight;

    // Configuration, generator and running sum registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg   <= KEY_COUNT_RESET;
            lfsr_reg        <= SEED_RESET;
            running_sum_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_KEY_COUNT)
            begin
                key_count_reg <= cfg_data[KC_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_LFSR_SEED)
            begin
                lfsr_reg <= cfg_data;
            end
            else if (ctrl.draw_start)
            begin
                lfsr_reg <= lfsr_next;
            end
            if (ctrl.load_write)
            begin
                running_sum_reg <= running_sum_next;
            end
        end
    end

    // Table writes go to keys inside the table only.
    assign wr_en   = ctrl.load_write && (32'(item.load_index) < 32'(MAX_KEYS));
    assign wr_addr = AW'(item.load_index);

    // A draw reads the last two entries; a search step reads mid and mid-1.
    assign addr_a = ctrl.draw_start ? last_idx   : mid_comb;
    assign addr_b = ctrl.draw_start ? penult_idx : mid_comb_m1;

    // Table memory with one write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= running_sum_next;
        end
        rd_a_reg <= table_mem[addr_a];
        rd_b_reg <= table_mem[addr_b];
    end

    // Search bounds.
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.init_bounds)
        begin
            lo_next = '0;
            hi_next = penult_idx;
        end
        else if (ctrl.set_lo)
        begin
            lo_next = mid_reg;
        end
        else if (ctrl.set_hi)
        begin
            hi_next = mid_reg;
        end
    end

    // Key chosen by the controller at the end of the search.
    always_comb
    begin
        unique case (ctrl.key_sel)
            KEY_LAST: key_pick = last_idx;
            KEY_LO:   key_pick = lo_reg;
            KEY_HI:   key_pick = hi_reg;
            KEY_MID:  key_pick = mid_reg;
            default:  key_pick = last_idx;
        endcase
    end

    // Search and result registers; these hold payload and need no reset.
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (ctrl.search_issue)
        begin
            mid_reg       <= mid_comb;
            mid_is_lo_reg <= (mid_comb == lo_reg);
        end
        if (ctrl.emit)
        begin
            key_reg    <= KEY_W'(key_pick);
            sample_reg <= lfsr_reg;
        end
    end

    // Compares against the registered read data.
    assign status.gt_a      = (lfsr_reg > rd_a_reg);
    assign status.gt_b      = (lfsr_reg > rd_b_reg);
    assign status.n_is_one  = n_is_one;
    assign status.mid_is_lo = mid_is_lo_reg;

    assign result.key    = key_reg;
    assign result.sample = sample_reg;

`ifndef SYNTHESIS
    // The search interval never inverts while a step is issued.
    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.search_issue |-> (lo_reg <= hi_reg))
        else $error("search interval inverted");

    // The latched midpoint lies inside the interval it was taken from.
    a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.search_issue |=> (mid_reg >= lo_reg && mid_reg <= hi_reg))
        else $error("midpoint outside search interval");
`endif

endmodule

// ===== design/lcks_controller.sv =====
// Controller of the key sampler: sequences the bounds check and the binary search.
module lcks_controller
    import lcks_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [0:0] item_cmd,
    input  status_t    status,
    output ctrl_t      ctrl,
    output logic       busy,
    output logic       done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST_CMP,
        ST_MID_RD,
        ST_MID_CMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    // Next state and datapath commands.
    always_comb
    begin
        state_next        = state_reg;
        ctrl              = '0;
        ctrl.key_sel      = KEY_LAST;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && item_cmd == CMD_LOAD)
                begin
                    ctrl.load_write = 1'b1;
                end
                else if (start && item_cmd == CMD_DRAW)
                begin
                    ctrl.draw_start = 1'b1;
                    state_next      = ST_FIRST_CMP;
                end
            end
            ST_FIRST_CMP:
            begin
                // Sample above the total rejects; else try the last key first.
                if (status.gt_a)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.n_is_one || status.gt_b)
                begin
                    ctrl.emit    = 1'b1;
                    ctrl.key_sel = KEY_LAST;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    ctrl.init_bounds = 1'b1;
                    state_next       = ST_MID_RD;
                end
            end
            ST_MID_RD:
            begin
                ctrl.search_issue = 1'b1;
                state_next        = ST_MID_CMP;
            end
            ST_MID_CMP:
            begin
                if (status.mid_is_lo)
                begin
                    ctrl.emit    = 1'b1;
                    ctrl.key_sel = status.gt_a ? KEY_HI : KEY_LO;
                    state_next   = ST_IDLE;
                end
                else if (!status.gt_a && status.gt_b)
                begin
                    ctrl.emit    = 1'b1;
                    ctrl.key_sel = KEY_MID;
                    state_next   = ST_IDLE;
                end
                else if (!status.gt_a)
                begin
                    ctrl.set_hi = 1'b1;
                    state_next  = ST_MID_RD;
                end
                else
                begin
                    ctrl.set_lo = 1'b1;
                    state_next  = ST_MID_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ctrl.emit;
        end
    end

`ifndef SYNTHESIS
    // A result word follows only a compare cycle.
    a_done_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_FIRST_CMP || $past(state_reg) == ST_MID_CMP))
        else $error("result strobe without a compare cycle");

    // An accepted draw occupies the block in the next cycle.
    a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item_cmd == CMD_DRAW) |=> busy)
        else $error("draw accepted but block not busy");

    // A load completes in its accept cycle.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item_cmd == CMD_LOAD) |=> !busy && !done)
        else $error("load left the block busy");
`endif

endmodule
